/* hdl/ps2q_pkg.sv */
// ps2q_pkg: types, constants and operation codes for the ps/2 mouse event queue
// shared by the response channel interface, the front end, the op queue, the back end and the top
// no dependencies
package ps2q_pkg;

	// event ring depth default and fixed field widths
	localparam int DEFAULT_EVENT_DEPTH = 64;
	localparam int LVL_W               = 7;
	localparam int OPQ_DEPTH           = 2;

	// header byte masks
	localparam logic [7:0] SYNC_MASK = 8'h08;
	localparam logic [7:0] OVF_MASK  = 8'hC0;
	localparam logic [7:0] BTN_MASK  = 8'h07;

	// request command codes
	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	// packet byte position
	typedef enum logic [1:0] {
		POS_HEADER = 2'd0,
		POS_X      = 2'd1,
		POS_Y      = 2'd2
	} pos_t;

	// operation handed from front to back
	typedef enum logic [1:0] {
		OP_FLAGS = 2'd0,
		OP_PUSH  = 2'd1,
		OP_POP   = 2'd2
	} op_kind_t;

	typedef struct packed {
		logic [2:0] buttons;
		logic [7:0] dy;
		logic [7:0] dx;
	} evt_t;

	typedef struct packed {
		op_kind_t kind;
		logic     handled;
		logic     sync_dropped;
		logic     overflow_dropped;
		evt_t     evt;
	} op_t;

endpackage

/* hdl/ps2q_ifs.sv */
// ps2q channel interfaces: request, response and configuration write channels
// each carries valid, ready and payload; depends on ps2q_pkg
interface ps2q_req_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic       aux_flag;
	logic [7:0] data_byte;

	modport source(output valid, output cmd, output aux_flag, output data_byte, input ready);
	modport sink(input valid, input cmd, input aux_flag, input data_byte, output ready);
endinterface

interface ps2q_rsp_if import ps2q_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              handled;
	logic              sync_dropped;
	logic              overflow_dropped;
	logic              full_dropped;
	logic              event_valid;
	logic signed [7:0] move_x;
	logic signed [7:0] move_y;
	logic [2:0]        button_bits;
	logic [LVL_W-1:0]  queue_level;

	modport source(output valid, output handled, output sync_dropped, output overflow_dropped,
		output full_dropped, output event_valid, output move_x, output move_y,
		output button_bits, output queue_level, input ready);
	modport sink(input valid, input handled, input sync_dropped, input overflow_dropped,
		input full_dropped, input event_valid, input move_x, input move_y,
		input button_bits, input queue_level, output ready);
endinterface

interface ps2q_cfg_if;
	logic valid;
	logic ready;
	logic enabled;

	modport source(output valid, output enabled, input ready);
	modport sink(input valid, input enabled, output ready);
endinterface

/* hdl/ps2q_front.sv */
// ps2q_front: accepts requests, holds the enable register and assembles packets
// emits one classified op per request; depends on ps2q_pkg and ps2q_ifs
module ps2q_front import ps2q_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	ps2q_req_if.sink      req,
	ps2q_cfg_if.sink      cfg,
	input  logic          op_ready,
	output logic          op_valid,
	output op_t           op
);

	pos_t       pos_q, pos_d;
	logic       enabled_q;
	logic [7:0] header_q, header_d;
	logic [7:0] x_q, x_d;
	logic [2:0] prior_btn_q, prior_btn_d;
	logic       prior_known_q, prior_known_d;
	logic       accept;
	logic [2:0] btn;

	// handshakes
	assign req.ready = op_ready;
	assign cfg.ready = 1'b1;
	assign accept    = req.valid & op_ready;
	assign op_valid  = accept;
	assign btn       = header_q[2:0] & BTN_MASK[2:0];

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
		end else if (cfg.valid) begin
			enabled_q <= cfg.enabled;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= POS_HEADER;
			prior_btn_q   <= '0;
			prior_known_q <= 1'b0;
		end else if (accept) begin
			pos_q         <= pos_d;
			prior_btn_q   <= prior_btn_d;
			prior_known_q <= prior_known_d;
		end
	end

	// packet byte holding registers
	always_ff @(posedge clk) begin
		if (accept) begin
			header_q <= header_d;
			x_q      <= x_d;
		end
	end

	// classify the request and compute next packet state
	always_comb begin
		pos_d         = pos_q;
		header_d      = header_q;
		x_d           = x_q;
		prior_btn_d   = prior_btn_q;
		prior_known_d = prior_known_q;
		op.kind             = OP_FLAGS;
		op.handled          = 1'b0;
		op.sync_dropped     = 1'b0;
		op.overflow_dropped = 1'b0;
		op.evt.buttons      = btn;
		op.evt.dy           = req.data_byte;
		op.evt.dx           = x_q;
		if (req.cmd == CMD_POP) begin
			op.kind = OP_POP;
		end else if (req.aux_flag) begin
			op.handled = 1'b1;
			if (enabled_q) begin
				unique case (pos_q)
					POS_HEADER: begin
						if ((req.data_byte & SYNC_MASK) == '0) begin
							op.sync_dropped = 1'b1;
						end else begin
							header_d = req.data_byte;
							pos_d    = POS_X;
						end
					end
					POS_X: begin
						x_d   = req.data_byte;
						pos_d = POS_Y;
					end
					default: begin
						pos_d = POS_HEADER;
						if ((header_q & OVF_MASK) != '0) begin
							op.overflow_dropped = 1'b1;
						end else if (!(x_q == '0 && req.data_byte == '0 && prior_known_q
								&& btn == prior_btn_q)) begin
							prior_btn_d   = btn;
							prior_known_d = 1'b1;
							op.kind       = OP_PUSH;
						end
					end
				endcase
			end
		end
	end

endmodule

/* hdl/ps2q_op_fifo.sv */
// ps2q_op_fifo: short queue of classified ops between front and back
// two entries, registered; depends on ps2q_pkg
module ps2q_op_fifo import ps2q_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  op_t  push_op,
	output logic pop_valid,
	input  logic pop_ready,
	output op_t  pop_op
);

	localparam int PTR_W = $clog2(OPQ_DEPTH);
	localparam int CNT_W = $clog2(OPQ_DEPTH + 1);

	op_t              entry_q [OPQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = cnt_q != CNT_W'(OPQ_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_op     = entry_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

/* hdl/ps2q_back.sv */
// ps2q_back: event ring memory, ring indexes and the registered response stage
// carries out push and pop ops in order; depends on ps2q_pkg and ps2q_ifs
module ps2q_back import ps2q_pkg::*; #(
	parameter int EVENT_DEPTH = DEFAULT_EVENT_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      op_valid,
	output logic      op_ready,
	input  op_t       op,
	ps2q_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(EVENT_DEPTH);
	localparam int CNT_W = $clog2(EVENT_DEPTH + 1);

	evt_t             ring [EVENT_DEPTH];
	evt_t             rd_data_q;
	logic [IDX_W-1:0] wr_idx_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             advance;
	logic             full;
	logic             empty;
	logic             do_write;
	logic             do_read;
	logic             out_valid_q;
	logic             handled_q;
	logic             sync_q;
	logic             ovf_q;
	logic             full_drop_q;
	logic             evt_valid_q;
	logic [LVL_W-1:0] level_q;

	// step when the response register is free or being drained
	assign advance  = op_valid & (~out_valid_q | rsp.ready);
	assign op_ready = advance;
	assign full     = count_q == CNT_W'(EVENT_DEPTH);
	assign empty    = count_q == '0;
	assign do_write = advance & (op.kind == OP_PUSH) & ~full;
	assign do_read  = advance & (op.kind == OP_POP) & ~empty;

	// next fill count
	always_comb begin
		count_d = count_q;
		if (do_write) begin
			count_d = count_q + 1'b1;
		end else if (do_read) begin
			count_d = count_q - 1'b1;
		end
	end

	// ring memory, registered read
	always_ff @(posedge clk) begin
		if (do_write) begin
			ring[wr_idx_q] <= op.evt;
		end
		if (do_read) begin
			rd_data_q <= ring[rd_idx_q];
		end
	end

	// ring indexes, count and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (do_write) begin
				wr_idx_q <= (wr_idx_q == IDX_W'(EVENT_DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
			end
			if (do_read) begin
				rd_idx_q <= (rd_idx_q == IDX_W'(EVENT_DEPTH - 1)) ? '0 : rd_idx_q + 1'b1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (advance) begin
			handled_q   <= op.handled;
			sync_q      <= op.sync_dropped;
			ovf_q       <= op.overflow_dropped;
			full_drop_q <= (op.kind == OP_PUSH) & full;
			evt_valid_q <= do_read;
			level_q     <= LVL_W'(count_d);
		end
	end

	// response outputs; event fields read as zero without an event
	assign rsp.valid            = out_valid_q;
	assign rsp.handled          = handled_q;
	assign rsp.sync_dropped     = sync_q;
	assign rsp.overflow_dropped = ovf_q;
	assign rsp.full_dropped     = full_drop_q;
	assign rsp.event_valid      = evt_valid_q;
	assign rsp.move_x           = evt_valid_q ? $signed(rd_data_q.dx) : '0;
	assign rsp.move_y           = evt_valid_q ? $signed(rd_data_q.dy) : '0;
	assign rsp.button_bits      = evt_valid_q ? rd_data_q.buttons : '0;
	assign rsp.queue_level      = level_q;

endmodule

/* hdl/ps2_mouse_packet_event_queue_top.sv */
// ps2_mouse_packet_event_queue_top: ps/2 mouse 3-byte packet decoder with event queue
// instantiates ps2q_front, ps2q_op_fifo and ps2q_back; depends on ps2q_pkg and ps2q_ifs
//
// usage:
//   req carries either a controller byte (cmd 0, with its aux flag) or a pop (cmd 1).
//   rsp returns exactly one result per request, in request order: drop flags for a
//   byte, or the oldest event for a pop, plus the event count after the request.
//   cfg writes the enabled bit; aux bytes are only decoded while it is set. write it
//   only while no request is in flight.
//   a transferred request passes through the op queue into the back end and its result
//   is registered in rsp; throughput is one request per cycle while rsp is not stalled,
//   set by the single-port ring access in the back end (one push or pop per cycle).
//   reset clears the packet position, last buttons, ring indexes, count and the rsp valid
//   flag; the ring contents are not cleared and no clearing pass runs.
//   when rsp stalls, the result register holds, the two-entry op queue fills and then
//   req.ready drops until the receiver takes a result.
module ps2_mouse_packet_event_queue_top import ps2q_pkg::*; #(
	parameter int EVENT_DEPTH = DEFAULT_EVENT_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	ps2q_req_if.sink   req,
	ps2q_cfg_if.sink   cfg,
	ps2q_rsp_if.source rsp
);

	logic fr_valid;
	logic fr_ready;
	op_t  fr_op;
	logic bk_valid;
	logic bk_ready;
	op_t  bk_op;

	// front end: accept and classify
	ps2q_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg      (cfg),
		.op_ready (fr_ready),
		.op_valid (fr_valid),
		.op       (fr_op)
	);

	// decoupling queue
	ps2q_op_fifo u_op_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_op    (fr_op),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_op     (bk_op)
	);

	// back end: ring and response
	ps2q_back #(
		.EVENT_DEPTH (EVENT_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (bk_valid),
		.op_ready (bk_ready),
		.op       (bk_op),
		.rsp      (rsp)
	);

endmodule
